/* rtl/ltt_pkg.sv */
// Shared types, sizes and codes for the LRU tag table.
package ltt_pkg;

  localparam int ENTRIES = 16;
  localparam int IDX_W   = 4;
  localparam int CAP_W   = 5;
  localparam int TAG_W   = 64;
  localparam int STAMP_W = 64;

  typedef enum logic {
    OP_LOOKUP   = 1'b0,
    OP_COMPLETE = 1'b1
  } op_e;

  typedef enum logic [2:0] {
    STAT_HIT_READY = 3'd0,
    STAT_HIT_PEND  = 3'd1,
    STAT_ALLOC     = 3'd2,
    STAT_NO_ROOM   = 3'd3,
    STAT_COMPLETED = 3'd4
  } status_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FINISH
  } state_e;

  typedef struct packed {
    logic               en_tag;
    logic               en_stamp;
    logic [IDX_W-1:0]   idx;
    logic [TAG_W-1:0]   tag;
    logic [STAMP_W-1:0] stamp;
  } store_wr_t;

  typedef struct packed {
    logic               valid;
    logic               pending;
    logic [IDX_W-1:0]   idx;
    logic [TAG_W-1:0]   tag;
    logic [STAMP_W-1:0] stamp;
  } cand_t;

  typedef struct packed {
    logic               free_found;
    logic [IDX_W-1:0]   free_idx;
    logic               vict_found;
    logic [IDX_W-1:0]   vict_idx;
    logic [STAMP_W-1:0] oldest;
  } best_t;

endpackage

/* rtl/ltt_store.sv */
// Tag and stamp memories: one write port, one registered read port.
module ltt_store
  import ltt_pkg::*;
(
  input  logic               clk_i,
  input  store_wr_t          wr_i,
  input  logic               rd_en_i,
  input  logic [IDX_W-1:0]   rd_idx_i,
  output logic [TAG_W-1:0]   rd_tag_o,
  output logic [STAMP_W-1:0] rd_stamp_o
);

  logic [TAG_W-1:0]   tag_mem   [ENTRIES];
  logic [STAMP_W-1:0] stamp_mem [ENTRIES];

  always_ff @(posedge clk_i) begin
    if (wr_i.en_tag) begin
      tag_mem[wr_i.idx] <= wr_i.tag;
    end
    if (wr_i.en_stamp) begin
      stamp_mem[wr_i.idx] <= wr_i.stamp;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_tag_o   <= tag_mem[rd_idx_i];
      rd_stamp_o <= stamp_mem[rd_idx_i];
    end
  end

endmodule

/* rtl/ltt_cmp.sv */
// Shared compare unit: tag match, first free slot and oldest evictable entry.
module ltt_cmp
  import ltt_pkg::*;
(
  input  logic [TAG_W-1:0] key_i,
  input  cand_t            cand_i,
  input  best_t            best_i,
  output logic             hit_o,
  output logic             hit_pend_o,
  output best_t            best_o
);

  always_comb begin
    hit_o      = cand_i.valid && (cand_i.tag == key_i);
    hit_pend_o = cand_i.pending;
    best_o     = best_i;
    if (!cand_i.valid) begin
      if (!best_i.free_found) begin
        best_o.free_found = 1'b1;
        best_o.free_idx   = cand_i.idx;
      end
    end else if (!cand_i.pending) begin
      if (!best_i.vict_found || (cand_i.stamp < best_i.oldest)) begin
        best_o.vict_found = 1'b1;
        best_o.vict_idx   = cand_i.idx;
        best_o.oldest     = cand_i.stamp;
      end
    end
  end

endmodule

/* rtl/lru_tag_table_with_pending_fill_core.sv */
// Top level: fully associative LRU tag table with pending fills.
//
// Command channel: an op word is taken at a clock edge with start_i high and
// busy_o low. opcode_i selects a lookup of key_tag_i or the completion of
// the fill of slot_index_i. busy_o stays high until the op is finished.
// Result channel: done_o is high for exactly one cycle with status_o,
// result_slot_o and evicted_o; the receiver cannot stall it.
// A lookup walks the effective capacity one slot per cycle through the
// single compare unit, reading tag and stamp from the slot memory; it stops
// at the first matching slot. When the scan ends, at a hit or past the
// last slot, the FINISH state sets done_o through its output register.
// A completion skips the scan and goes from accept straight to FINISH.
// A new op is taken in the cycle that shows done_o.
// capacity_we_i / capacity_i write the capacity register; the user is to
// write it only while idle, which the block itself does not enforce;
// zero acts as one, values above 16 act as 16.
// Reset clears all valid and pending marks, the use sequence and sets
// capacity to 16; tag and stamp memories are not cleared.
module lru_tag_table_with_pending_fill_core
  import ltt_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  output logic             busy_o,
  input  logic             opcode_i,
  input  logic [TAG_W-1:0] key_tag_i,
  input  logic [IDX_W-1:0] slot_index_i,
  input  logic             capacity_we_i,
  input  logic [CAP_W-1:0] capacity_i,
  output logic             done_o,
  output logic [2:0]       status_o,
  output logic [IDX_W-1:0] result_slot_o,
  output logic             evicted_o
);

  state_e             state_q, state_d;
  logic [CAP_W-1:0]   cfg_cap_q;
  op_e                op_q, op_d;
  logic [TAG_W-1:0]   key_q, key_d;
  logic [IDX_W-1:0]   slot_q, slot_d;
  logic [CAP_W-1:0]   cap_q, cap_d;
  logic [CAP_W-1:0]   rd_cnt_q, rd_cnt_d;
  logic               cmp_act_q, cmp_act_d;
  logic [IDX_W-1:0]   cmp_idx_q, cmp_idx_d;
  best_t              best_q, best_d;
  logic               hit_q, hit_d;
  logic               hit_pend_q, hit_pend_d;
  logic [IDX_W-1:0]   hit_idx_q, hit_idx_d;
  logic [ENTRIES-1:0] valid_q, valid_d;
  logic [ENTRIES-1:0] pend_q, pend_d;
  logic [STAMP_W-1:0] seq_q, seq_d;
  logic               done_q, done_d;
  status_e            status_q, status_d;
  logic [IDX_W-1:0]   rslot_q, rslot_d;
  logic               evict_q, evict_d;

  logic [CAP_W-1:0]   cap_eff;
  store_wr_t          wr;
  logic               rd_en;
  logic [IDX_W-1:0]   rd_idx;
  logic [TAG_W-1:0]   rd_tag;
  logic [STAMP_W-1:0] rd_stamp;
  cand_t              cand;
  logic               cmp_hit;
  logic               cmp_hit_pend;
  best_t              cmp_best;
  logic [STAMP_W-1:0] seq_inc;

  ltt_store u_store (
    .clk_i      (clk_i),
    .wr_i       (wr),
    .rd_en_i    (rd_en),
    .rd_idx_i   (rd_idx),
    .rd_tag_o   (rd_tag),
    .rd_stamp_o (rd_stamp)
  );

  always_comb begin
    cand.valid   = valid_q[cmp_idx_q];
    cand.pending = pend_q[cmp_idx_q];
    cand.idx     = cmp_idx_q;
    cand.tag     = rd_tag;
    cand.stamp   = rd_stamp;
  end

  ltt_cmp u_cmp (
    .key_i      (key_q),
    .cand_i     (cand),
    .best_i     (best_q),
    .hit_o      (cmp_hit),
    .hit_pend_o (cmp_hit_pend),
    .best_o     (cmp_best)
  );

  always_comb begin
    if (cfg_cap_q == '0) begin
      cap_eff = CAP_W'(1);
    end else if (cfg_cap_q > CAP_W'(ENTRIES)) begin
      cap_eff = CAP_W'(ENTRIES);
    end else begin
      cap_eff = cfg_cap_q;
    end
  end

  assign seq_inc = seq_q + STAMP_W'(1);

  always_comb begin
    state_d    = state_q;
    op_d       = op_q;
    key_d      = key_q;
    slot_d     = slot_q;
    cap_d      = cap_q;
    rd_cnt_d   = rd_cnt_q;
    cmp_act_d  = cmp_act_q;
    cmp_idx_d  = cmp_idx_q;
    best_d     = best_q;
    hit_d      = hit_q;
    hit_pend_d = hit_pend_q;
    hit_idx_d  = hit_idx_q;
    valid_d    = valid_q;
    pend_d     = pend_q;
    seq_d      = seq_q;
    done_d     = 1'b0;
    status_d   = status_q;
    rslot_d    = rslot_q;
    evict_d    = evict_q;
    rd_en      = 1'b0;
    rd_idx     = rd_cnt_q[IDX_W-1:0];
    wr         = '0;
    wr.tag     = key_q;
    wr.stamp   = seq_inc;

    unique case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          op_d      = op_e'(opcode_i);
          key_d     = key_tag_i;
          slot_d    = slot_index_i;
          cap_d     = cap_eff;
          rd_cnt_d  = '0;
          cmp_act_d = 1'b0;
          best_d    = '0;
          hit_d     = 1'b0;
          state_d   = (op_e'(opcode_i) == OP_COMPLETE) ? ST_FINISH : ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (rd_cnt_q < cap_q) begin
          rd_en     = 1'b1;
          rd_cnt_d  = rd_cnt_q + CAP_W'(1);
          cmp_act_d = 1'b1;
          cmp_idx_d = rd_cnt_q[IDX_W-1:0];
        end else begin
          cmp_act_d = 1'b0;
        end
        if (cmp_act_q) begin
          best_d = cmp_best;
          if (cmp_hit) begin
            hit_d      = 1'b1;
            hit_pend_d = cmp_hit_pend;
            hit_idx_d  = cmp_idx_q;
            cmp_act_d  = 1'b0;
            state_d    = ST_FINISH;
          end
        end else if (rd_cnt_q >= cap_q) begin
          state_d = ST_FINISH;
        end
      end
      ST_FINISH: begin
        state_d = ST_IDLE;
        done_d  = 1'b1;
        evict_d = 1'b0;
        if (op_q == OP_COMPLETE) begin
          status_d = STAT_COMPLETED;
          rslot_d  = slot_q;
          if (valid_q[slot_q] && pend_q[slot_q]) begin
            pend_d[slot_q] = 1'b0;
            wr.en_stamp    = 1'b1;
            wr.idx         = slot_q;
            seq_d          = seq_inc;
          end
        end else if (hit_q) begin
          rslot_d = hit_idx_q;
          if (hit_pend_q) begin
            status_d = STAT_HIT_PEND;
          end else begin
            status_d    = STAT_HIT_READY;
            wr.en_stamp = 1'b1;
            wr.idx      = hit_idx_q;
            seq_d       = seq_inc;
          end
        end else if (best_q.free_found || best_q.vict_found) begin
          status_d    = STAT_ALLOC;
          wr.idx      = best_q.free_found ? best_q.free_idx : best_q.vict_idx;
          rslot_d     = wr.idx;
          evict_d     = !best_q.free_found;
          wr.en_tag   = 1'b1;
          wr.en_stamp = 1'b1;
          valid_d[wr.idx] = 1'b1;
          pend_d[wr.idx]  = 1'b1;
          seq_d       = seq_inc;
        end else begin
          status_d = STAT_NO_ROOM;
          rslot_d  = '0;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      cfg_cap_q <= CAP_W'(ENTRIES);
      valid_q   <= '0;
      pend_q    <= '0;
      seq_q     <= '0;
      done_q    <= 1'b0;
      cmp_act_q <= 1'b0;
      rd_cnt_q  <= '0;
      hit_q     <= 1'b0;
    end else begin
      state_q   <= state_d;
      valid_q   <= valid_d;
      pend_q    <= pend_d;
      seq_q     <= seq_d;
      done_q    <= done_d;
      cmp_act_q <= cmp_act_d;
      rd_cnt_q  <= rd_cnt_d;
      hit_q     <= hit_d;
      if (capacity_we_i) begin
        cfg_cap_q <= capacity_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    op_q       <= op_d;
    key_q      <= key_d;
    slot_q     <= slot_d;
    cap_q      <= cap_d;
    cmp_idx_q  <= cmp_idx_d;
    best_q     <= best_d;
    hit_pend_q <= hit_pend_d;
    hit_idx_q  <= hit_idx_d;
    status_q   <= status_d;
    rslot_q    <= rslot_d;
    evict_q    <= evict_d;
  end

  assign busy_o        = (state_q != ST_IDLE);
  assign done_o        = done_q;
  assign status_o      = status_q;
  assign result_slot_o = rslot_q;
  assign evicted_o     = evict_q;

  a_busy_after_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |=> busy_o)
    else $error("busy not raised after accepted word");

  a_done_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o)
    else $error("result strobe held for more than one cycle");

  a_evict_alloc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && evicted_o) |-> (status_o == STAT_ALLOC))
    else $error("eviction flagged without allocation");

  a_no_room_slot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && status_o == STAT_NO_ROOM) |-> (result_slot_o == '0))
    else $error("no-room result carries a slot");

endmodule
